FILE: rtl/dh_forward_kinematics_chain_core_assert.svh
// Assertion macros for the kinematics chain RTL.
`ifndef DH_FORWARD_KINEMATICS_CHAIN_CORE_ASSERT_SVH
`define DH_FORWARD_KINEMATICS_CHAIN_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define DHFK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be true outside reset.
`define DHFK_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define DHFK_ASSERT(lbl, clk, rst, prop, msg)
`define DHFK_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

FILE: rtl/dhfk_pkg.sv
// Shared types, constants and helper functions of the kinematics chain.
package dhfk_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int FRAC_BITS_DEF         = 16;

  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;

  typedef enum logic [2:0] {
    MOP_T01, MOP_T02, MOP_T03, MOP_T11, MOP_T12, MOP_T13, MOP_MAC
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLOAD, ST_CITER, ST_CSTORE, ST_TMUL, ST_MAC,
    ST_DRAIN, ST_COPY, ST_LOAD, ST_WAIT
  } ctrl_state_t;

  typedef struct packed {
    logic       capture;
    logic       cordic_load;
    logic       cordic_sel;    // 0 theta, 1 alpha
    logic       cordic_step;
    logic [4:0] iter;
    logic       cordic_store;
    logic       mul_go;
    mul_op_t    op;
    logic [1:0] r;
    logic [1:0] c;
    logic [1:0] k;
    logic       copy;
    logic       out_load;
    logic [1:0] out_row;
    logic       ident;
  } dhfk_cmd_t;

  typedef struct packed {
    logic last;
    logic out_valid;
    logic out_taken;
  } dhfk_sts_t;

  function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:    atan_q30 = 35'sd843314856;
      5'd1:    atan_q30 = 35'sd497837829;
      5'd2:    atan_q30 = 35'sd263043836;
      5'd3:    atan_q30 = 35'sd133525158;
      5'd4:    atan_q30 = 35'sd67021686;
      5'd5:    atan_q30 = 35'sd33543515;
      5'd6:    atan_q30 = 35'sd16775850;
      5'd7:    atan_q30 = 35'sd8388437;
      5'd8:    atan_q30 = 35'sd4194282;
      5'd9:    atan_q30 = 35'sd2097149;
      5'd10:   atan_q30 = 35'sd1048575;
      5'd11:   atan_q30 = 35'sd524287;
      5'd12:   atan_q30 = 35'sd262143;
      5'd13:   atan_q30 = 35'sd131071;
      5'd14:   atan_q30 = 35'sd65535;
      5'd15:   atan_q30 = 35'sd32767;
      5'd16:   atan_q30 = 35'sd16383;
      5'd17:   atan_q30 = 35'sd8191;
      5'd18:   atan_q30 = 35'sd4095;
      5'd19:   atan_q30 = 35'sd2047;
      5'd20:   atan_q30 = 35'sd1023;
      5'd21:   atan_q30 = 35'sd511;
      5'd22:   atan_q30 = 35'sd255;
      5'd23:   atan_q30 = 35'sd127;
      default: atan_q30 = 35'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = {1'b0, {31{1'b1}}};
    end else if (v < -64'sd2147483648) begin
      sat32 = {1'b1, {31{1'b0}}};
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

FILE: rtl/dhfk_ctrl.sv
// Sequencer for CORDIC passes, multiply schedule and result emission.
`include "dh_forward_kinematics_chain_core_assert.svh"
module dhfk_ctrl #(
  parameter int CORDIC_ITERATIONS = dhfk_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output dhfk_pkg::dhfk_cmd_t   cmd,
  input  dhfk_pkg::dhfk_sts_t   sts
);

  localparam logic [4:0] LAST_IT = 5'(CORDIC_ITERATIONS - 1);

  dhfk_pkg::ctrl_state_t state, state_next;
  logic       pass, pass_next;
  logic [4:0] iter, iter_next;
  logic [2:0] tcnt, tcnt_next;
  logic [1:0] r, r_next, c, c_next, k, k_next, row, row_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dhfk_pkg::ST_IDLE;
      pass  <= 1'b0;
      iter  <= '0;
      tcnt  <= '0;
      r     <= '0;
      c     <= '0;
      k     <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      iter  <= iter_next;
      tcnt  <= tcnt_next;
      r     <= r_next;
      c     <= c_next;
      k     <= k_next;
      row   <= row_next;
    end
  end

  always_comb begin
    state_next = state;
    pass_next  = pass;
    iter_next  = iter;
    tcnt_next  = tcnt;
    r_next     = r;
    c_next     = c;
    k_next     = k;
    row_next   = row;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      dhfk_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          pass_next   = 1'b0;
          state_next  = dhfk_pkg::ST_CLOAD;
        end
      end
      dhfk_pkg::ST_CLOAD: begin
        cmd.cordic_load = 1'b1;
        cmd.cordic_sel  = pass;
        iter_next       = '0;
        state_next      = dhfk_pkg::ST_CITER;
      end
      dhfk_pkg::ST_CITER: begin
        cmd.cordic_step = 1'b1;
        cmd.iter        = iter;
        if (iter == LAST_IT) begin
          state_next = dhfk_pkg::ST_CSTORE;
        end else begin
          iter_next = iter + 5'd1;
        end
      end
      dhfk_pkg::ST_CSTORE: begin
        cmd.cordic_store = 1'b1;
        cmd.cordic_sel   = pass;
        if (pass) begin
          tcnt_next  = '0;
          state_next = dhfk_pkg::ST_TMUL;
        end else begin
          pass_next  = 1'b1;
          state_next = dhfk_pkg::ST_CLOAD;
        end
      end
      dhfk_pkg::ST_TMUL: begin
        cmd.mul_go = 1'b1;
        cmd.op     = dhfk_pkg::mul_op_t'(tcnt);
        if (tcnt == 3'd5) begin
          r_next     = '0;
          c_next     = '0;
          k_next     = '0;
          state_next = dhfk_pkg::ST_MAC;
        end else begin
          tcnt_next = tcnt + 3'd1;
        end
      end
      dhfk_pkg::ST_MAC: begin
        cmd.mul_go = 1'b1;
        cmd.op     = dhfk_pkg::MOP_MAC;
        cmd.r      = r;
        cmd.c      = c;
        cmd.k      = k;
        // column 3 takes a fourth term: the old translation times one
        if (k == ((c == 2'd3) ? 2'd3 : 2'd2)) begin
          k_next = '0;
          if (c == 2'd3) begin
            c_next = '0;
            if (r == 2'd2) begin
              state_next = dhfk_pkg::ST_DRAIN;
            end else begin
              r_next = r + 2'd1;
            end
          end else begin
            c_next = c + 2'd1;
          end
        end else begin
          k_next = k + 2'd1;
        end
      end
      dhfk_pkg::ST_DRAIN: begin
        state_next = dhfk_pkg::ST_COPY;
      end
      dhfk_pkg::ST_COPY: begin
        cmd.copy = 1'b1;
        if (sts.last) begin
          row_next   = '0;
          state_next = dhfk_pkg::ST_LOAD;
        end else begin
          state_next = dhfk_pkg::ST_IDLE;
        end
      end
      dhfk_pkg::ST_LOAD: begin
        cmd.out_load = 1'b1;
        cmd.out_row  = row;
        state_next   = dhfk_pkg::ST_WAIT;
      end
      dhfk_pkg::ST_WAIT: begin
        if (sts.out_taken) begin
          if (row == 2'd3) begin
            cmd.ident  = 1'b1;
            state_next = dhfk_pkg::ST_IDLE;
          end else begin
            row_next   = row + 2'd1;
            state_next = dhfk_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_next = dhfk_pkg::ST_IDLE;
      end
    endcase
  end

  `DHFK_ASSERT(a_mac_row, clk, rst, (state == dhfk_pkg::ST_MAC) |-> (r != 2'd3), "mac row out of range")
  `DHFK_ASSERT(a_mac_k, clk, rst, (state == dhfk_pkg::ST_MAC && k == 2'd3) |-> (c == 2'd3), "fourth term off column 3")
  `DHFK_ASSERT(a_alpha_mul, clk, rst, (state == dhfk_pkg::ST_CSTORE && pass) |=> (state == dhfk_pkg::ST_TMUL), "no multiply after alpha pass")
  `DHFK_NEVER(a_load_busy, clk, rst, cmd.out_load && sts.out_valid, "output load over pending beat")
  `DHFK_NEVER(a_cap_busy, clk, rst, cmd.capture && sts.out_valid, "capture while result pending")

endmodule

FILE: rtl/dhfk_dp.sv
// Datapath: input capture, shared CORDIC, shared multiplier, matrices, output register.
module dhfk_dp #(
  parameter int FRAC_BITS = dhfk_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dhfk_pkg::dhfk_cmd_t  cmd,
  output dhfk_pkg::dhfk_sts_t  sts,
  input  logic signed [17:0]   joint_angle,
  input  logic signed [23:0]   offset_d,
  input  logic signed [23:0]   length_a,
  input  logic signed [17:0]   twist_alpha,
  input  logic                 last_row,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           row_index,
  output logic signed [31:0]   col0,
  output logic signed [31:0]   col1,
  output logic signed [31:0]   col2,
  output logic signed [31:0]   col3,
  output logic                 last_of_run
);

  localparam int LSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int RSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int CRS = 30 - FRAC_BITS;
  localparam logic signed [39:0] LHALF = (40'sd1 <<< RSH) >>> 1;
  localparam logic signed [33:0] CHALF = (34'sd1 <<< CRS) >>> 1;
  localparam logic signed [63:0] MHALF = (64'sd1 <<< FRAC_BITS) >>> 1;
  localparam logic signed [31:0] ONE   = 32'sd1 <<< FRAC_BITS;

  // captured item
  logic signed [17:0] th_q, al_q;
  logic signed [31:0] d_q, a_q;
  logic               last_q;
  logic signed [39:0] d_sh, a_sh;

  assign d_sh = ((40'(offset_d) <<< LSH) + LHALF) >>> RSH;
  assign a_sh = ((40'(length_a) <<< LSH) + LHALF) >>> RSH;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      th_q   <= joint_angle;
      al_q   <= twist_alpha;
      last_q <= last_row;
      d_q    <= dhfk_pkg::sat32(64'(d_sh));
      a_q    <= dhfk_pkg::sat32(64'(a_sh));
    end
  end

  // CORDIC, one micro-rotation per cycle
  logic signed [33:0] x, y, xs, ys, xr, yr;
  logic signed [34:0] z, z_raw, z_red, at;
  logic signed [17:0] ang;
  logic               cneg, neg_red;
  logic signed [31:0] st, ct, sa, ca;

  always_comb begin
    ang   = cmd.cordic_sel ? al_q : th_q;
    z_raw = 35'(ang) <<< 15;
    if (z_raw > dhfk_pkg::HALF_PI_Q30) begin
      z_red   = z_raw - dhfk_pkg::PI_Q30;
      neg_red = 1'b1;
    end else if (z_raw < -dhfk_pkg::HALF_PI_Q30) begin
      z_red   = z_raw + dhfk_pkg::PI_Q30;
      neg_red = 1'b1;
    end else begin
      z_red   = z_raw;
      neg_red = 1'b0;
    end
    xs = x >>> cmd.iter;
    ys = y >>> cmd.iter;
    at = dhfk_pkg::atan_q30(cmd.iter);
    xr = (x + CHALF) >>> CRS;
    yr = (y + CHALF) >>> CRS;
    if (cneg) begin
      xr = -xr;
      yr = -yr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cordic_load) begin
      x    <= dhfk_pkg::CORDIC_K;
      y    <= '0;
      z    <= z_red;
      cneg <= neg_red;
    end else if (cmd.cordic_step) begin
      if (!z[34]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
    if (cmd.cordic_store) begin
      if (cmd.cordic_sel) begin
        ca <= xr[31:0];
        sa <= yr[31:0];
      end else begin
        ct <= xr[31:0];
        st <= yr[31:0];
      end
    end
  end

  // link transform products and accumulated matrices
  logic signed [31:0] t01, t02, t03, t11, t12, t13;
  logic signed [31:0] acc [3][4];
  logic signed [31:0] nm  [3][4];
  logic signed [31:0] acc_rd, t_rd, ma, mb;

  always_comb begin
    acc_rd = '0;
    case (cmd.r)
      2'd0:    acc_rd = acc[0][cmd.k];
      2'd1:    acc_rd = acc[1][cmd.k];
      2'd2:    acc_rd = acc[2][cmd.k];
      default: acc_rd = '0;
    endcase
    case ({cmd.k, cmd.c})
      4'b0000: t_rd = ct;
      4'b0001: t_rd = t01;
      4'b0010: t_rd = t02;
      4'b0011: t_rd = t03;
      4'b0100: t_rd = st;
      4'b0101: t_rd = t11;
      4'b0110: t_rd = t12;
      4'b0111: t_rd = t13;
      4'b1001: t_rd = sa;
      4'b1010: t_rd = ca;
      4'b1011: t_rd = d_q;
      4'b1111: t_rd = ONE;
      default: t_rd = '0;
    endcase
    case (cmd.op)
      dhfk_pkg::MOP_T01: begin ma = st;  mb = ca; end
      dhfk_pkg::MOP_T02: begin ma = st;  mb = sa; end
      dhfk_pkg::MOP_T03: begin ma = a_q; mb = ct; end
      dhfk_pkg::MOP_T11: begin ma = ct;  mb = ca; end
      dhfk_pkg::MOP_T12: begin ma = ct;  mb = sa; end
      dhfk_pkg::MOP_T13: begin ma = a_q; mb = st; end
      default:           begin ma = acc_rd; mb = t_rd; end
    endcase
  end

  // multiply stage, then round and accumulate stage
  logic signed [63:0] p, rnd, sum, s_new;
  logic signed [31:0] rs, rneg;
  logic               pv;
  dhfk_pkg::mul_op_t  pop;
  logic [1:0]         pr, pc, pk;

  always_ff @(posedge clk) begin
    p   <= ma * mb;
    pop <= cmd.op;
    pr  <= cmd.r;
    pc  <= cmd.c;
    pk  <= cmd.k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= cmd.mul_go;
    end
  end

  always_comb begin
    rnd   = (p + MHALF) >>> FRAC_BITS;
    rs    = dhfk_pkg::sat32(rnd);
    rneg  = dhfk_pkg::sat32(-(64'(rs)));
    s_new = ((pk == 2'd0) ? 64'sd0 : sum) + rnd;
  end

  always_ff @(posedge clk) begin
    if (pv) begin
      case (pop)
        dhfk_pkg::MOP_T01: t01 <= rneg;
        dhfk_pkg::MOP_T02: t02 <= rs;
        dhfk_pkg::MOP_T03: t03 <= rs;
        dhfk_pkg::MOP_T11: t11 <= rs;
        dhfk_pkg::MOP_T12: t12 <= rneg;
        dhfk_pkg::MOP_T13: t13 <= rs;
        default: begin
          sum <= s_new;
          if (pk == 2'd3 || (pk == 2'd2 && pc != 2'd3)) begin
            nm[pr][pc] <= dhfk_pkg::sat32(s_new);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.ident) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) begin
          acc[i][j] <= (i == j) ? ONE : 32'sd0;
        end
      end
    end else if (cmd.copy) begin
      acc <= nm;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      row_index   <= cmd.out_row;
      last_of_run <= (cmd.out_row == 2'd3);
      case (cmd.out_row)
        2'd0:    begin col0 <= acc[0][0]; col1 <= acc[0][1]; col2 <= acc[0][2]; col3 <= acc[0][3]; end
        2'd1:    begin col0 <= acc[1][0]; col1 <= acc[1][1]; col2 <= acc[1][2]; col3 <= acc[1][3]; end
        2'd2:    begin col0 <= acc[2][0]; col1 <= acc[2][1]; col2 <= acc[2][2]; col3 <= acc[2][3]; end
        default: begin col0 <= '0; col1 <= '0; col2 <= '0; col3 <= ONE; end
      endcase
    end
  end

  assign sts.last      = last_q;
  assign sts.out_valid = out_valid;
  assign sts.out_taken = out_valid & out_ready;

endmodule

FILE: rtl/dh_forward_kinematics_chain_core.sv
// Top level of the Denavit-Hartenberg forward kinematics chain.
//
//  channel | handshake          | beat contents
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_ready  | joint_angle, offset_d, length_a, twist_alpha,
//          |                    | last_row (one DH row)
//  out     | out_valid/out_ready| row_index, col0..col3, last_of_run
//
// Each row takes two passes of the one-rotation-per-cycle CORDIC, then
// 45 issues on the single 32x32 multiplier (6 transform terms, 39 matrix
// terms) plus drain and copy. A last row adds four output beats.
// Reset loads the accumulated matrix with identity and drops any pending beat.
// A stalled output holds the block; the next row is taken only once the
// fourth beat has left.
module dh_forward_kinematics_chain_core #(
  parameter int CORDIC_ITERATIONS = dhfk_pkg::CORDIC_ITERATIONS_DEF,
  parameter int FRAC_BITS         = dhfk_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [17:0] joint_angle,
  input  logic signed [23:0] offset_d,
  input  logic signed [23:0] length_a,
  input  logic signed [17:0] twist_alpha,
  input  logic               last_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         row_index,
  output logic signed [31:0] col0,
  output logic signed [31:0] col1,
  output logic signed [31:0] col2,
  output logic signed [31:0] col3,
  output logic               last_of_run
);

  // command and status between sequencer and datapath
  dhfk_pkg::dhfk_cmd_t cmd;
  dhfk_pkg::dhfk_sts_t sts;

  dhfk_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .sts     (sts)
  );

  dhfk_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .joint_angle(joint_angle),
    .offset_d   (offset_d),
    .length_a   (length_a),
    .twist_alpha(twist_alpha),
    .last_row   (last_row),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_index  (row_index),
    .col0       (col0),
    .col1       (col1),
    .col2       (col2),
    .col3       (col3),
    .last_of_run(last_of_run)
  );

endmodule

FILE: tb/sv/dh_forward_kinematics_chain_core_tb.sv
// Self-checking testbench for the DH forward kinematics chain core.
module dh_forward_kinematics_chain_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NITER = dhfk_pkg::CORDIC_ITERATIONS_DEF;
  localparam int FRAC = dhfk_pkg::FRAC_BITS_DEF;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam logic signed [17:0] ANG_MAX = 18'sd102944;
  localparam longint LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [17:0] joint_angle = '0;
  logic signed [23:0] offset_d = '0;
  logic signed [23:0] length_a = '0;
  logic signed [17:0] twist_alpha = '0;
  logic last_row = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] row_index;
  logic signed [31:0] col0, col1, col2, col3;
  logic last_of_run;

  typedef struct {
    logic [1:0] row;
    logic signed [31:0] c [4];
    logic last;
  } pose_row_t;

  pose_row_t pose_q[$];
  longint chain_m[3][4];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit stall_en = 1'b1;
  bit gaps_en = 1'b1;

  dh_forward_kinematics_chain_core DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("dh_forward_kinematics_chain_core test failed");
      $finish;
    end
  end

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rnd(longint v, int s);
    if (s == 0) return v;
    return asr(v + (64'sd1 <<< (s - 1)), s);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clamp32(rnd(a * b, FRAC));
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
    return tbl[i];
  endfunction

  // Rotation-mode CORDIC with quadrant fold; matches the block bit for bit.
  task automatic rotate(input longint ang, output longint s, output longint c);
    longint z, x, y, nx;
    bit neg;
    z = ang * 32768;
    x = 652032874;
    y = 0;
    neg = 1'b0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; neg = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; neg = 1'b1;
    end
    for (int i = 0; i < NITER && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i); y = y + asr(x, i); z -= arctan_step(i);
      end else begin
        nx = x + asr(y, i); y = y - asr(x, i); z += arctan_step(i);
      end
      x = nx;
    end
    x = rnd(x, 30 - FRAC);
    y = rnd(y, 30 - FRAC);
    if (neg) begin
      x = -x; y = -y;
    end
    c = clamp32(x);
    s = clamp32(y);
  endtask

  function automatic void reset_chain();
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        chain_m[r][c] = (r == c) ? ONE : 0;
  endfunction

  // Fold one DH link into the chain; on the last link queue the four pose rows.
  task automatic chain_link(input logic signed [17:0] th, input logic signed [23:0] d,
                            input logic signed [23:0] a, input logic signed [17:0] al,
                            input logic last);
    longint st, ct, sa, ca, t[3][4], nm[3][4], acc, dd, aa;
    pose_row_t pr;
    rotate(th, st, ct);
    rotate(al, sa, ca);
    dd = clamp32(longint'(d) * (64'sd1 <<< (FRAC - 16)));
    aa = clamp32(longint'(a) * (64'sd1 <<< (FRAC - 16)));
    t[0][0] = ct; t[0][1] = clamp32(-qmul(st, ca));
    t[0][2] = qmul(st, sa); t[0][3] = qmul(aa, ct);
    t[1][0] = st; t[1][1] = qmul(ct, ca);
    t[1][2] = clamp32(-qmul(ct, sa)); t[1][3] = qmul(aa, st);
    t[2][0] = 0; t[2][1] = sa; t[2][2] = ca; t[2][3] = dd;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rnd(chain_m[r][k] * t[k][c], FRAC);
        if (c == 3) acc += chain_m[r][3];
        nm[r][c] = clamp32(acc);
      end
    chain_m = nm;
    if (last) begin
      for (int r = 0; r < 4; r++) begin
        pr.row = 2'(r);
        for (int c = 0; c < 4; c++)
          pr.c[c] = 32'((r < 3) ? chain_m[r][c] : ((c == 3) ? ONE : 0));
        pr.last = (r == 3);
        pose_q.push_back(pr);
      end
      reset_chain();
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // Receiver: random stall pattern, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if (!stall_en) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    pose_row_t w;
    if (!rst && out_valid && out_ready) begin
      if (pose_q.size() == 0) begin
        errors++;
        $display("mismatch: output beat with nothing expected");
      end else begin
        w = pose_q.pop_front();
        if (row_index !== w.row) report("row_index", row_index, w.row);
        if (col0 !== w.c[0]) report("col0", col0, w.c[0]);
        if (col1 !== w.c[1]) report("col1", col1, w.c[1]);
        if (col2 !== w.c[2]) report("col2", col2, w.c[2]);
        if (col3 !== w.c[3]) report("col3", col3, w.c[3]);
        if (last_of_run !== w.last) report("last_of_run", last_of_run, w.last);
      end
    end
  end

  int burst_left = 0;

  // Offer one row and hold it until accepted; gaps come between bursts.
  task automatic send_link(input logic signed [17:0] th, input logic signed [23:0] d,
                           input logic signed [23:0] a, input logic signed [17:0] al,
                           input logic last);
    if (gaps_en) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 6);
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
      burst_left--;
    end
    joint_angle <= th; offset_d <= d; length_a <= a; twist_alpha <= al;
    last_row <= last; in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    chain_link(th, d, a, al, last);
    @(negedge clk);
    in_valid <= 1'b0;
    // leave this edge before the next beat raises valid again
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pose_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [17:0] any_angle();
    case ($urandom_range(0, 3))
      0: return 18'($urandom);
      1: return ($urandom_range(0, 1) ? ANG_MAX : -ANG_MAX);
      default: return $signed(18'($urandom_range(0, 2 * ANG_MAX))) - ANG_MAX;
    endcase
  endfunction

  function automatic logic signed [23:0] any_len();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($signed(24'($urandom_range(0, 1 << 20))) - (1 << 19));
      2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      default: return 24'($signed(24'($urandom_range(0, 1 << 18))) - (1 << 17));
    endcase
  endfunction

  // Extremes of every field, quarter-turn folding and saturation.
  task automatic test_directed();
    send_link(0, 0, 0, 0, 1);
    send_link(ANG_MAX, 24'sh7fffff, 24'sh7fffff, ANG_MAX, 1);
    send_link(-ANG_MAX, 24'sh800000, 24'sh800000, -ANG_MAX, 1);
    send_link(18'sh1ffff, 24'sh7fffff, 24'sh7fffff, 18'sh20000, 1);
    send_link(18'sh20000, 24'sh800000, 24'sh7fffff, 18'sh1ffff, 1);
    send_link(51472, 65536, 65536, 51472, 0);
    send_link(51473, -65536, 131072, -51473, 0);
    send_link(-51472, 0, 24'sh7fffff, 51480, 1);
    for (int i = 0; i < 6; i++)
      send_link(ANG_MAX / 7, 24'sh7fffff, 24'sh7fffff, 0, i == 5);
    send_link(-1, 1, -1, 1, 1);
    send_link(25736, 24'h555555, 24'haaaaaa, -25736, 1);
    wait_drained();
  endtask

  // Back-pressure: hold the receiver while rows keep arriving.
  task automatic test_backpressure();
    gaps_en = 1'b0;
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send_link(any_angle(), any_len(), any_len(), any_angle(), 1'(i % 2));
    join
    wait_drained();
    gaps_en = 1'b1;
  endtask

  // Random chains of 1..8 links, with some runs free of stalls.
  task automatic test_random_chains();
    int sent = 0, n;
    while (sent < 330) begin
      n = $urandom_range(1, 8);
      stall_en = ($urandom_range(0, 4) != 0);
      gaps_en = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < n; i++)
        send_link(any_angle(), any_len(), any_len(), any_angle(), i == n - 1);
      sent += n;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    stall_en = 1'b1;
    gaps_en = 1'b1;
  endtask

  initial begin
    reset_chain();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random_chains();
    wait_drained();
    repeat (300) @(negedge clk);
    if (errors == 0 && pose_q.size() == 0) begin
      $display("dh_forward_kinematics_chain_core test passed");
    end else begin
      $display("dh_forward_kinematics_chain_core test failed");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/dhfk_pkg.sv
rtl/dhfk_ctrl.sv
rtl/dhfk_dp.sv
rtl/dh_forward_kinematics_chain_core.sv
tb/sv/dh_forward_kinematics_chain_core_tb.sv
